// ===== sv/lifo_stack_with_search_defines.svh =====
// Assertion macros shared by the checker of the stack.
// Both macros sample on the rising edge of clk_i and are off while rst_ni is low.
`ifndef LIFO_STACK_WITH_SEARCH_DEFINES_SVH
`define LIFO_STACK_WITH_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stack check failed");

// The consequent must hold in the cycle after the antecedent.
`define LSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stack check failed");

`endif

// ===== sv/lss_pkg.sv =====
package lss_pkg;

  localparam int ValueFieldWidth = 32;
  localparam int CountFieldWidth = 9;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP      = 2'd1,
    OP_PEEK     = 2'd2,
    OP_CONTAINS = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    FAULT_OK    = 2'd0,
    FAULT_EMPTY = 2'd1,
    FAULT_FULL  = 2'd2
  } fault_e;

  typedef struct packed {
    logic [ValueFieldWidth-1:0] read_value;
    logic                       found;
    fault_e                     fault;
    logic [CountFieldWidth-1:0] entry_count;
    logic                       is_empty;
  } res_t;

endpackage

// ===== sv/lss_ram.sv =====
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds its value while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/lifo_stack_with_search.sv =====
// LIFO stack of DEPTH entries with a search operation, held in one single-port-read
// RAM with a registered read. One request gives one result. A push, and any request
// that faults, completes in IDLE; pop and peek go through READ for one RAM read;
// contains on an empty stack completes in IDLE, and otherwise steps through SCAN,
// comparing entries from the top down until a match or the bottom, since the scan reads
// one entry per cycle through the single read port. A finished result goes to an output
// register, or waits in ST_DONE while that register is stalled; a new request is taken
// only in IDLE, not while a result waits in ST_DONE. Entry count and empty flag are
// taken after the operation; no clearing is needed, as only written entries are ever read.
module lifo_stack_with_search #(
  parameter int DEPTH       = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  lss_pkg::op_e                          op_i,
  input  logic [lss_pkg::ValueFieldWidth-1:0]   item_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [lss_pkg::ValueFieldWidth-1:0]   read_value_o,
  output logic                                  found_o,
  output lss_pkg::fault_e                       fault_o,
  output logic [lss_pkg::CountFieldWidth-1:0]   entry_count_o,
  output logic                                  is_empty_o
);

  import lss_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = VALUE_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [VW-1:0]   key_q;
  res_t            res_q, res_d;
  res_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [VW-1:0]   rdata;
  logic [VW-1:0]   key_in;
  logic [VW+ValueFieldWidth-1:0] key_wide;
  logic [VW+ValueFieldWidth-1:0] rdata_wide;
  logic [ValueFieldWidth-1:0]    rdata_field;
  logic [CW-1:0]   count_dec;
  logic [CW-1:0]   count_sel;
  logic [CW+CountFieldWidth-1:0] count_wide;
  logic            accept, out_free, is_full, is_empty;
  logic            done_valid;
  res_t            done_res;

  // Zero-extend or truncate between the fixed field widths and the stored width.
  assign key_wide    = {{VW{1'b0}}, item_value_i};
  assign key_in      = key_wide[VW-1:0];
  assign rdata_wide  = {{ValueFieldWidth{1'b0}}, rdata};
  assign rdata_field = rdata_wide[ValueFieldWidth-1:0];

  assign count_dec = count_q - CW'(1);
  assign is_full   = (count_q == CW'(DEPTH));
  assign is_empty  = (count_q == '0);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign count_wide = {{CountFieldWidth{1'b0}}, count_sel};

  lss_ram #(
    .WIDTH(VW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (key_in),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = count_q[AW-1:0];
    raddr      = count_dec[AW-1:0];
    done_valid = 1'b0;
    done_res   = '0;
    count_sel  = count_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_PUSH: begin
              done_valid = 1'b1;
              if (is_full) begin
                done_res.fault = FAULT_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            OP_POP, OP_PEEK: begin
              if (is_empty) begin
                done_valid     = 1'b1;
                done_res.fault = FAULT_EMPTY;
              end else begin
                re      = 1'b1;
                state_d = ST_READ;
                if (op_i == OP_POP) begin
                  count_d = count_dec;
                end
              end
            end
            default: begin
              if (is_empty) begin
                done_valid = 1'b1;
              end else begin
                re      = 1'b1;
                ptr_d   = count_dec[AW-1:0];
                state_d = ST_SCAN;
              end
            end
          endcase
        end
        count_sel = count_d;
      end
      ST_READ: begin
        done_valid          = 1'b1;
        done_res.read_value = rdata_field;
      end
      ST_SCAN: begin
        // The entry at ptr_q was read last cycle; stop on a match or at the bottom.
        if (rdata == key_q || ptr_q == '0) begin
          done_valid     = 1'b1;
          done_res.found = (rdata == key_q);
        end else begin
          re    = 1'b1;
          raddr = ptr_q - AW'(1);
          ptr_d = ptr_q - AW'(1);
        end
      end
      ST_DONE: begin
        done_valid = 1'b1;
        done_res   = res_q;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (state_q != ST_DONE) begin
      done_res.entry_count = count_wide[CountFieldWidth-1:0];
      done_res.is_empty    = (count_sel == '0);
    end

    if (done_valid) begin
      state_d = out_free ? ST_IDLE : ST_DONE;
    end
  end

  always_comb begin
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (done_valid && !out_free) begin
      res_d = done_res;
    end
    if (out_free) begin
      out_valid_d = done_valid;
      if (done_valid) begin
        out_d = done_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    res_q <= res_d;
    out_q <= out_d;
    if (accept) begin
      key_q <= key_in;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_q.read_value;
  assign found_o       = out_q.found;
  assign fault_o       = out_q.fault;
  assign entry_count_o = out_q.entry_count;
  assign is_empty_o    = out_q.is_empty;

endmodule

// ===== sv/lss_checker.sv =====
`include "lifo_stack_with_search_defines.svh"

module lss_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input lss_pkg::op_e                        op_i,
  input logic [lss_pkg::ValueFieldWidth-1:0] item_value_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [lss_pkg::ValueFieldWidth-1:0] read_value_o,
  input logic                                found_o,
  input lss_pkg::fault_e                     fault_o,
  input logic [lss_pkg::CountFieldWidth-1:0] entry_count_o,
  input logic                                is_empty_o
);

  import lss_pkg::*;

  res_t out_res;
  logic read_zero;

  assign out_res   = {read_value_o, found_o, fault_o, entry_count_o, is_empty_o};
  assign read_zero = (read_value_o == '0);

  // A stalled result must not move.
  `LSS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_res))

  // An empty stack always reports a zero entry count.
  `LSS_ASSERT_IMP(a_empty_count, out_valid_o && is_empty_o, entry_count_o == '0)

  // An empty fault reads nothing and leaves the stack empty.
  `LSS_ASSERT_IMP(a_empty_fault, out_valid_o && fault_o == FAULT_EMPTY, is_empty_o && read_zero)

  // A match can only come from a fault-free search of a non-empty stack.
  `LSS_ASSERT_IMP(a_found_ok, out_valid_o && found_o, fault_o == FAULT_OK && !is_empty_o)

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (.*);
